// ----- hdl/pressed_key_set_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pressed key set tracker
// Shared property wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PRESSED_KEY_SET_TRACKER_DEFINES_SVH
`define PRESSED_KEY_SET_TRACKER_DEFINES_SVH

// same-cycle implication
`define PKST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PKST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pkst_pkg.sv -----
// ----------------------------------------------------------------------------
// pkst_pkg
// Shared constants and link types for the held key list.
// ----------------------------------------------------------------------------
package pkst_pkg;

    localparam int KEY_SLOTS = 16;
    localparam int CODE_W    = 7;
    localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
    localparam int COUNT_W   = 5;

    // token that walks down the chain, with the match-seen flag
    typedef struct packed {
        logic tok;
        logic fnd;
    } link_t;

    // values broadcast to every cell
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  total;
        logic              append;
        logic              release_op;
    } bcast_t;

endpackage

// ----- hdl/pkst_cell.sv -----
// ----------------------------------------------------------------------------
// pkst_cell
// One slot of the held key list: compares when the token passes and, on a
// release, pulls the upper neighbor's key down once an earlier slot matched.
// ----------------------------------------------------------------------------
module pkst_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pkst_pkg::CNT_W-1:0]   slot_idx,
    input  pkst_pkg::bcast_t             bcast,
    input  pkst_pkg::link_t              lnk_in,
    output pkst_pkg::link_t              lnk_out,
    input  logic [pkst_pkg::CODE_W-1:0]  up_key,
    input  logic                         up_pull,
    output logic [pkst_pkg::CODE_W-1:0]  key,
    output logic                         pull
);
    import pkst_pkg::*;

    logic              tok_reg;
    logic              fnd_reg;
    logic [CODE_W-1:0] key_reg;
    logic              slot_valid;
    logic              match;

    assign slot_valid = (slot_idx < bcast.total);
    assign match      = tok_reg && slot_valid && (key_reg == bcast.code);

    assign lnk_out.tok = tok_reg;
    assign lnk_out.fnd = fnd_reg | match;
    assign pull        = tok_reg & fnd_reg & bcast.release_op;
    assign key         = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            fnd_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= lnk_in.tok;
            fnd_reg <= lnk_in.fnd;
        end
    end

    // the upper slot hands its key down after a deletion point; an append writes the code into slot total
    always_ff @(posedge clk)
    begin
        if (up_pull)
            key_reg <= up_key;
        else if (bcast.append && (slot_idx == bcast.total))
            key_reg <= bcast.code;
    end

endmodule

// ----- hdl/pressed_key_set_tracker.sv -----
// ----------------------------------------------------------------------------
// pressed_key_set_tracker
// Ordered list of held keys built from scancode bytes, one slot per cell.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  request   start, scan_byte (busy is out)            in
//  result    done, key_code .. click_byte              out
//  config    click_wr, click_data                      in
//
// A request walks a token down the KEY_SLOTS cells, one cell per cycle; done
// is registered from the token leaving the last cell, and busy drops as done
// rises, so the next request can be taken at the edge that ends the done
// cycle; no new request is taken while a token is in the chain.
// Reset clears the count, the click value and all control; slot contents are
// only read below the count. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "pressed_key_set_tracker_defines.svh"

module pressed_key_set_tracker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] scan_byte,
    input  logic       click_wr,
    input  logic [7:0] click_data,
    output logic       done,
    output logic [6:0] key_code,
    output logic       is_press,
    output logic       key_added,
    output logic       already_held,
    output logic       key_removed,
    output logic       release_missing,
    output logic       list_full_drop,
    output logic [4:0] held_count,
    output logic       click_send,
    output logic [7:0] click_byte
);
    import pkst_pkg::*;

    logic              busy_reg;
    logic [CODE_W-1:0] code_reg;
    logic              press_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;
    logic [7:0]        click_reg;

    logic              accept;
    logic              fin;
    logic              found;
    logic              new_press;
    logic              has_room;

    logic              done_reg;
    logic [6:0]        key_code_reg;
    logic              is_press_reg;
    logic              added_reg, added_next;
    logic              held_reg, held_next;
    logic              removed_reg, removed_next;
    logic              missing_reg, missing_next;
    logic              dropped_reg, dropped_next;
    logic              send_reg, send_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    logic [4:0]        outcome_vec;

    bcast_t            bcast;
    link_t             lnk  [KEY_SLOTS+1];
    logic [CODE_W-1:0] keys [KEY_SLOTS+1];
    logic              pulls[KEY_SLOTS+1];
    logic [KEY_SLOTS-1:0] tok_vec;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    assign lnk[0].tok     = accept;
    assign lnk[0].fnd     = 1'b0;
    assign keys[KEY_SLOTS]  = '0;
    assign pulls[KEY_SLOTS] = 1'b0;

    assign fin       = lnk[KEY_SLOTS].tok;
    assign found     = lnk[KEY_SLOTS].fnd;
    assign has_room  = (total_reg < CNT_W'(KEY_SLOTS));
    assign new_press = press_reg && (code_reg != '0) && !found;

    assign bcast.code       = code_reg;
    assign bcast.total      = total_reg;
    assign bcast.append     = fin && new_press && has_room;
    assign bcast.release_op = !press_reg;

    genvar gi;
    generate
        for (gi = 0; gi < KEY_SLOTS; gi++)
        begin : g_cell
            pkst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .slot_idx (CNT_W'(gi)),
                .bcast    (bcast),
                .lnk_in   (lnk[gi]),
                .lnk_out  (lnk[gi+1]),
                .up_key   (keys[gi+1]),
                .up_pull  (pulls[gi+1]),
                .key      (keys[gi]),
                .pull     (pulls[gi])
            );
            assign tok_vec[gi] = lnk[gi+1].tok;
        end
    endgenerate

    always_comb
    begin
        added_next   = 1'b0;
        held_next    = 1'b0;
        removed_next = 1'b0;
        missing_next = 1'b0;
        dropped_next = 1'b0;
        send_next    = 1'b0;
        total_next   = total_reg;
        if (press_reg)
        begin
            if (code_reg != '0)
            begin
                if (found)
                    held_next = 1'b1;
                else
                begin
                    if (has_room)
                    begin
                        added_next = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    else
                        dropped_next = 1'b1;
                    send_next = (click_reg != 8'h00);
                end
            end
        end
        else if (found)
        begin
            removed_next = 1'b1;
            total_next   = total_reg - 1'b1;
        end
        else
            missing_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            total_reg <= '0;
            click_reg <= 8'h00;
        end
        else
        begin
            if (click_wr)
                click_reg <= click_data;
            if (accept)
                busy_reg <= 1'b1;
            else if (fin)
                busy_reg <= 1'b0;
            done_reg <= fin;
            if (fin)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= scan_byte[6:0];
            press_reg <= !scan_byte[7];
        end
        if (fin)
        begin
            key_code_reg <= code_reg;
            is_press_reg <= press_reg;
            added_reg    <= added_next;
            held_reg     <= held_next;
            removed_reg  <= removed_next;
            missing_reg  <= missing_next;
            dropped_reg  <= dropped_next;
            send_reg     <= send_next;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, total_reg};

    assign done            = done_reg;
    assign key_code        = key_code_reg;
    assign is_press        = is_press_reg;
    assign key_added       = added_reg;
    assign already_held    = held_reg;
    assign key_removed     = removed_reg;
    assign release_missing = missing_reg;
    assign list_full_drop  = dropped_reg;
    assign held_count      = count_ext[COUNT_W-1:0];
    assign click_send      = send_reg;
    assign click_byte      = send_reg ? click_reg : 8'h00;

    assign outcome_vec = {added_reg, held_reg, removed_reg, missing_reg, dropped_reg};

    `PKST_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one token in the chain")
    `PKST_ASSERT_NOW(a_count_range, 1'b1, total_reg <= CNT_W'(KEY_SLOTS), "held count overflow")
    `PKST_ASSERT_NOW(a_one_outcome, done_reg, $onehot0(outcome_vec), "conflicting outcome flags")
    `PKST_ASSERT_NEXT(a_busy_after_accept, accept, busy_reg, "request accepted but not busy")
    `PKST_ASSERT_NEXT(a_single_strobe, done_reg, !done_reg, "result strobe longer than one cycle")

endmodule

// ----- sim/pkst_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkst_result_checker
// Watches the request, result and click register ports of the key tracker,
// keeps its own held key list, and compares every result strobe against the
// oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module pkst_result_checker
    import pkst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [7:0] scan_byte,
    input  logic       click_wr,
    input  logic [7:0] click_data,
    input  logic       done,
    input  logic [6:0] key_code,
    input  logic       is_press,
    input  logic       key_added,
    input  logic       already_held,
    input  logic       key_removed,
    input  logic       release_missing,
    input  logic       list_full_drop,
    input  logic [4:0] held_count,
    input  logic       click_send,
    input  logic [7:0] click_byte,
    output int         mismatch_count,
    output int         pending_results
);

    typedef struct packed {
        logic [CODE_W-1:0]  key_code;
        logic               is_press;
        logic               key_added;
        logic               already_held;
        logic               key_removed;
        logic               release_missing;
        logic               list_full_drop;
        logic [COUNT_W-1:0] held_count;
        logic               click_send;
        logic [7:0]         click_byte;
    } key_result_t;

    logic [CODE_W-1:0] held_list [KEY_SLOTS];
    int                held_n;
    logic [7:0]        click_reg;
    key_result_t       due_results [$];
    key_result_t       due_r;
    int                errs;

    // Applies one scancode to the shadow list and returns the result it causes.
    function automatic key_result_t track_scan(input logic [7:0] b);
        key_result_t       r;
        logic [CODE_W-1:0] code;
        int                slot;
        bit                found;
        r = '0;
        code = b[CODE_W-1:0];
        r.key_code = code;
        r.is_press = !b[7];
        slot = 0;
        while (slot < held_n && held_list[slot] != code)
            slot++;
        found = (slot < held_n);
        if (r.is_press) begin
            // code zero press is ignored entirely
            if (code != '0) begin
                if (found) begin
                    r.already_held = 1'b1;
                end
                else begin
                    if (held_n < KEY_SLOTS) begin
                        held_list[held_n] = code;
                        held_n++;
                        r.key_added = 1'b1;
                    end
                    else begin
                        r.list_full_drop = 1'b1;
                    end
                    // dropped presses still click
                    r.click_send = (click_reg != 8'h00);
                end
            end
        end
        else if (found) begin
            for (int i = slot; i + 1 < held_n; i++)
                held_list[i] = held_list[i + 1];
            held_n--;
            r.key_removed = 1'b1;
        end
        else begin
            r.release_missing = 1'b1;
        end
        r.held_count = COUNT_W'(held_n);
        r.click_byte = r.click_send ? click_reg : 8'h00;
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [7:0] exp_v,
                                     input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_n = 0;
            click_reg = 8'h00;
            due_results.delete();
            mismatch_count = 0;
            pending_results = 0;
        end
        else begin
            if (click_wr)
                click_reg = click_data;
            if (start && !busy)
                due_results.push_back(track_scan(scan_byte));
            if (done) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual key_code %h",
                             $time, key_code);
                    mismatch_count++;
                end
                else begin
                    due_r = due_results.pop_front();
                    errs = field_bad("key_code", 8'(due_r.key_code), 8'(key_code))
                         + field_bad("is_press", 8'(due_r.is_press), 8'(is_press))
                         + field_bad("key_added", 8'(due_r.key_added), 8'(key_added))
                         + field_bad("already_held", 8'(due_r.already_held),
                                     8'(already_held))
                         + field_bad("key_removed", 8'(due_r.key_removed), 8'(key_removed))
                         + field_bad("release_missing", 8'(due_r.release_missing),
                                     8'(release_missing))
                         + field_bad("list_full_drop", 8'(due_r.list_full_drop),
                                     8'(list_full_drop))
                         + field_bad("held_count", 8'(due_r.held_count), 8'(held_count))
                         + field_bad("click_send", 8'(due_r.click_send), 8'(click_send))
                         + field_bad("click_byte", due_r.click_byte, click_byte);
                    mismatch_count += errs;
                end
            end
            pending_results = due_results.size();
        end
    end

endmodule

// ----- sim/pressed_key_set_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressed_key_set_tracker_tb
// Drives scancode requests and click register writes into the key tracker:
// a directed pass over the corner cases, then phases of random press and
// release traffic over small code pools so the list fills and drains.
// ----------------------------------------------------------------------------
module pressed_key_set_tracker_tb;
    import pkst_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int PHASE_ITEMS    = 85;
    localparam int POOL_SIZE      = 24;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic [7:0] scan_byte;
    logic       click_wr;
    logic [7:0] click_data;
    logic       busy;
    logic       done;
    logic [6:0] key_code;
    logic       is_press;
    logic       key_added;
    logic       already_held;
    logic       key_removed;
    logic       release_missing;
    logic       list_full_drop;
    logic [4:0] held_count;
    logic       click_send;
    logic [7:0] click_byte;

    int mismatch_count;
    int pending_results;
    int idle_cycles;
    bit idle_on;

    logic [7:0]        phase_click [5];
    logic [CODE_W-1:0] code_pool [POOL_SIZE];
    int                press_pct;
    logic [7:0]        rnd_byte;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pressed_key_set_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .scan_byte      (scan_byte),
        .click_wr       (click_wr),
        .click_data     (click_data),
        .done           (done),
        .key_code       (key_code),
        .is_press       (is_press),
        .key_added      (key_added),
        .already_held   (already_held),
        .key_removed    (key_removed),
        .release_missing(release_missing),
        .list_full_drop (list_full_drop),
        .held_count     (held_count),
        .click_send     (click_send),
        .click_byte     (click_byte)
    );

    pkst_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .scan_byte      (scan_byte),
        .click_wr       (click_wr),
        .click_data     (click_data),
        .done           (done),
        .key_code       (key_code),
        .is_press       (is_press),
        .key_added      (key_added),
        .already_held   (already_held),
        .key_removed    (key_removed),
        .release_missing(release_missing),
        .list_full_drop (list_full_drop),
        .held_count     (held_count),
        .click_send     (click_send),
        .click_byte     (click_byte),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    // Called at a rising edge; returns at the edge where the request is taken.
    // While idle_on is set, start idles low at random each cycle, so idles land on ready cycles too.
    task automatic send_scan(input logic [7:0] b);
        bit taken;
        taken = 1'b0;
        scan_byte <= b;
        while (!taken) begin
            start <= !(idle_on && ($urandom_range(99) < 31));
            @(posedge clk);
            taken = start && !busy;
        end
    endtask

    // Drops start and waits until every request has its result back.
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_click(input logic [7:0] v);
        click_wr <= 1'b1;
        click_data <= v;
        @(posedge clk);
        click_wr <= 1'b0;
    endtask

    // Stall watchdog: nothing moving on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        scan_byte = 8'h00;
        click_wr = 1'b0;
        click_data = 8'h00;
        idle_cycles = 0;
        idle_on = 1'b1;
        phase_click[0] = 8'h00;
        phase_click[1] = 8'hFF;
        phase_click[2] = 8'h01;
        phase_click[3] = 8'($urandom);
        phase_click[4] = 8'h80;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_click(8'h5A);

        // directed corners
        send_scan(8'h00);           // press of code zero, ignored
        send_scan(8'h80);           // release of code zero, always missing
        send_scan(8'h7F);
        send_scan(8'h7F);           // already held
        send_scan(8'hFF);
        send_scan(8'hFF);           // release not in list
        for (int k = 1; k <= KEY_SLOTS; k++)
            send_scan(8'(k));
        send_scan(8'h40);           // list full, dropped but clicks
        send_scan(8'h88);           // remove from the middle
        send_scan(8'h81);           // remove the oldest
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            write_click(phase_click[ph]);
            idle_on = (ph != 2);
            press_pct = (ph % 2 == 0) ? 70 : 45;
            for (int k = 0; k < POOL_SIZE; k++)
                code_pool[k] = CODE_W'($urandom_range(1, 127));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 8)
                    rnd_byte = 8'($urandom);
                else
                    rnd_byte = {($urandom_range(99) >= press_pct),
                                code_pool[$urandom_range(POOL_SIZE - 1)]};
                send_scan(rnd_byte);
            end
            settle();
        end

        repeat (KEY_SLOTS + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
